[rtl/ttfd_pkg.sv]
// Shared types, format codes and channel widening helpers for the tiled texel decoder.
`timescale 1ns / 1ps

package ttfd_pkg;

  // Raster index width of an output pixel
  localparam int PIX_IDX_W = 20;

  // Source texel format codes
  localparam logic [3:0] FMT_RGBA8    = 4'd0;
  localparam logic [3:0] FMT_RGB8     = 4'd1;
  localparam logic [3:0] FMT_RGBA5551 = 4'd2;
  localparam logic [3:0] FMT_RGB565   = 4'd3;
  localparam logic [3:0] FMT_RGBA4    = 4'd4;
  localparam logic [3:0] FMT_LA8      = 4'd5;
  localparam logic [3:0] FMT_HILO8    = 4'd6;
  localparam logic [3:0] FMT_L8       = 4'd7;
  localparam logic [3:0] FMT_A8       = 4'd8;
  localparam logic [3:0] FMT_LA4      = 4'd9;
  localparam logic [3:0] FMT_L4       = 4'd10;
  localparam logic [3:0] FMT_A4       = 4'd11;

  // Configuration register indexes
  localparam logic [1:0] CFG_FORMAT = 2'd0;
  localparam logic [1:0] CFG_ACROSS = 2'd1;
  localparam logic [1:0] CFG_DOWN   = 2'd2;

  localparam logic [7:0] CH_FULL = 8'hFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct packed {
    logic [PIX_IDX_W-1:0] pixel_index;
    rgba_t                color;
    logic                 run_end;
    logic                 image_end;
  } pix_rec_t;

  // Bytes that make up one texel of a format
  function automatic logic [2:0] texel_bytes(input logic [3:0] fmt);
    logic [2:0] n;
    if (fmt == FMT_RGBA8) n = 3'd4;
    else if (fmt == FMT_RGB8) n = 3'd3;
    else if (fmt <= FMT_HILO8) n = 3'd2;
    else n = 3'd1;
    return n;
  endfunction

  // Bit replication widening to eight bits
  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

endpackage

[rtl/ttfd_byte_if.sv]
// Byte stream channel carrying the tiled source texture.
`timescale 1ns / 1ps

interface ttfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/ttfd_pixel_if.sv]
// Pixel channel carrying decoded RGBA8 pixels with their raster index.
`timescale 1ns / 1ps

interface ttfd_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [ttfd_pkg::PIX_IDX_W-1:0] pixel_index;
  logic [7:0]                    red;
  logic [7:0]                    green;
  logic [7:0]                    blue;
  logic [7:0]                    alpha;
  logic                          run_end;
  logic                          image_end;

  modport source (output valid, output pixel_index, output red, output green, output blue,
                  output alpha, output run_end, output image_end, input ready);
  modport sink (input valid, input pixel_index, input red, input green, input blue,
                input alpha, input run_end, input image_end, output ready);
endinterface

[rtl/ttfd_cfg_if.sv]
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface ttfd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/ttfd_color.sv]
// Texel word to RGBA8 conversion for every source format (two pixels for L4 and A4).
`timescale 1ns / 1ps

module ttfd_color (
  input  logic [3:0]      texel_format,
  input  logic [31:0]     word,
  output ttfd_pkg::rgba_t first,
  output ttfd_pkg::rgba_t second
);
  import ttfd_pkg::*;

  logic [7:0]  b0, b1, b2, b3;
  logic [15:0] h;
  logic [7:0]  lo4, hi4;

  assign b0  = word[7:0];
  assign b1  = word[15:8];
  assign b2  = word[23:16];
  assign b3  = word[31:24];
  assign h   = word[15:0];
  assign lo4 = widen4(b0[3:0]);
  assign hi4 = widen4(b0[7:4]);

  // Per-format channel mapping
  always_comb begin
    first  = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: CH_FULL};
    second = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: CH_FULL};
    case (texel_format)
      FMT_RGBA8: first = '{red: b1, green: b2, blue: b3, alpha: b0};
      FMT_RGB8: first = '{red: b0, green: b1, blue: b2, alpha: CH_FULL};
      FMT_RGBA5551: begin
        first = '{red: widen5(h[5:1]), green: widen5(h[10:6]), blue: widen5(h[15:11]),
                  alpha: {8{h[0]}}};
      end
      FMT_RGB565: begin
        first = '{red: widen5(h[4:0]), green: widen6(h[10:5]), blue: widen5(h[15:11]),
                  alpha: CH_FULL};
      end
      FMT_RGBA4: begin
        first = '{red: widen4(h[7:4]), green: widen4(h[11:8]), blue: widen4(h[15:12]),
                  alpha: widen4(h[3:0])};
      end
      FMT_LA8, FMT_HILO8: first = '{red: b0, green: b0, blue: b0, alpha: b1};
      FMT_L8: first = '{red: b0, green: b0, blue: b0, alpha: CH_FULL};
      FMT_A8: first = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: b0};
      FMT_LA4: first = '{red: hi4, green: hi4, blue: hi4, alpha: lo4};
      // low nibble first, high nibble second
      FMT_L4: begin
        first  = '{red: lo4, green: lo4, blue: lo4, alpha: CH_FULL};
        second = '{red: hi4, green: hi4, blue: hi4, alpha: CH_FULL};
      end
      FMT_A4: begin
        first  = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: lo4};
        second = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: hi4};
      end
      default: begin
        first  = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: CH_FULL};
        second = '{red: CH_FULL, green: CH_FULL, blue: CH_FULL, alpha: CH_FULL};
      end
    endcase
  end

endmodule

[rtl/tiled_texel_format_decoder_top.sv]
// Top level of the tiled texel format decoder: byte gathering, tile walk and output queue.
// Takes a tiled texture one byte per transaction and returns RGBA8 pixels, each tagged
// with its raster index; tiles of 8x8 pixels are walked in row order and the pixels
// inside a tile in Morton order. A byte is taken in every cycle while the output side
// keeps up. Multi-byte texels give their pixel on the transaction of the last byte; L4
// and A4 bytes give two pixels, which leave one after the other through the single
// pixel port, so for those formats a new byte is taken only once the first has left.
// A pixel appears on the output in the cycle after the byte that completes it is taken.
// Any configuration write restarts the image at the first pixel; write only while no
// pixel is pending. Format codes 12 to 15 swallow bytes without output.
`timescale 1ns / 1ps

module tiled_texel_format_decoder_top #(
  parameter int MAX_TILES = 128
) (
  input logic        clk,
  input logic        rst,
  ttfd_byte_if.sink  byte_in,
  ttfd_pixel_if.source pixel_out,
  ttfd_cfg_if.sink   cfg
);
  import ttfd_pkg::*;

  localparam int TW     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW     = $clog2(MAX_TILES + 1);
  localparam int CMP_W  = (CW > 8) ? CW : 8;
  localparam int POS_W  = TW + 3;
  localparam int SPAN_W = POS_W + CW;
  localparam int PROD_W = SPAN_W + 3;
  localparam int IDX_W  = (PROD_W > PIX_IDX_W) ? PROD_W : PIX_IDX_W;

  // Configuration registers
  logic [3:0] texel_format;
  logic [7:0] tiles_across;
  logic [7:0] tiles_down;

  // Position and gathering state
  logic [23:0]   byte_collector, byte_collector_next;
  logic [1:0]    bytes_held, bytes_held_next;
  logic [5:0]    pixel_in_tile, pixel_in_tile_next;
  logic [TW-1:0] tile_column, tile_column_next;
  logic [TW-1:0] tile_row, tile_row_next;

  // Two-entry output queue
  pix_rec_t   q_slot [2];
  pix_rec_t   q_slot_next [2];
  logic [1:0] q_cnt, q_cnt_next;

  logic cfg_fire, in_fire, out_fire;

  // Handshakes
  assign cfg.ready       = 1'b1;
  assign cfg_fire        = cfg.valid && cfg.ready;
  assign byte_in.ready   = (q_cnt == 2'd0) || ((q_cnt == 2'd1) && pixel_out.ready);
  assign in_fire         = byte_in.valid && byte_in.ready;
  assign pixel_out.valid = (q_cnt != 2'd0);
  assign out_fire        = pixel_out.valid && pixel_out.ready;

  assign pixel_out.pixel_index = q_slot[0].pixel_index;
  assign pixel_out.red         = q_slot[0].color.red;
  assign pixel_out.green       = q_slot[0].color.green;
  assign pixel_out.blue        = q_slot[0].color.blue;
  assign pixel_out.alpha       = q_slot[0].color.alpha;
  assign pixel_out.run_end     = q_slot[0].run_end;
  assign pixel_out.image_end   = q_slot[0].image_end;

  // Effective tile counts: zero acts as one, large values saturate
  logic [CMP_W-1:0] across_ext, down_ext;
  logic [CW-1:0]    across_eff, down_eff;

  assign across_ext = CMP_W'(tiles_across);
  assign down_ext   = CMP_W'(tiles_down);

  always_comb begin
    if (across_ext == '0) across_eff = CW'(1);
    else if (across_ext > CMP_W'(MAX_TILES)) across_eff = CW'(MAX_TILES);
    else across_eff = CW'(across_ext);
    if (down_ext == '0) down_eff = CW'(1);
    else if (down_ext > CMP_W'(MAX_TILES)) down_eff = CW'(MAX_TILES);
    else down_eff = CW'(down_ext);
  end

  // Texel gathering
  logic        fmt_ok, collecting;
  logic [2:0]  need;
  logic [1:0]  last_slot;
  logic [31:0] word;
  logic [23:0] collector_add;
  logic [1:0]  n_res;

  assign fmt_ok     = (texel_format <= FMT_A4);
  assign need       = texel_bytes(texel_format);
  assign collecting = (({1'b0, bytes_held} + 3'd1) < need);
  assign last_slot  = need[1:0] - 2'd1;
  assign word       = {8'b0, byte_collector}
                    | ({24'b0, byte_in.data_byte} << {last_slot, 3'b000});
  assign collector_add = byte_collector
                       | 24'({24'b0, byte_in.data_byte} << {bytes_held, 3'b000});

  always_comb begin
    if (!fmt_ok || collecting) n_res = 2'd0;
    else if ((texel_format == FMT_L4) || (texel_format == FMT_A4)) n_res = 2'd2;
    else n_res = 2'd1;
  end

  // Colors
  rgba_t pix0, pix1;

  ttfd_color u_color (
    .texel_format (texel_format),
    .word         (word),
    .first        (pix0),
    .second       (pix1)
  );

  // Raster index from the Morton position; two-pixel bytes start on an even pixel
  logic [2:0]           ox, oy;
  logic [POS_W-1:0]     col, row;
  logic [SPAN_W-1:0]    row_span;
  logic [IDX_W-1:0]     idx_full;
  logic [PIX_IDX_W-1:0] idx0, idx1;

  assign ox       = {pixel_in_tile[4], pixel_in_tile[2], pixel_in_tile[0]};
  assign oy       = {pixel_in_tile[5], pixel_in_tile[3], pixel_in_tile[1]};
  assign col      = {tile_column, ox};
  assign row      = {tile_row, oy};
  assign row_span = SPAN_W'(row) * SPAN_W'(across_eff);
  assign idx_full = IDX_W'(col) + IDX_W'({row_span, 3'b000});
  assign idx0     = idx_full[PIX_IDX_W-1:0];
  assign idx1     = idx0 + PIX_IDX_W'(1);

  // Position advance
  logic [6:0] p_sum;
  logic       tile_wrap, col_last, row_last, end_hit;

  assign p_sum     = {1'b0, pixel_in_tile} + ((n_res == 2'd2) ? 7'd2 : 7'd1);
  assign tile_wrap = p_sum[6];
  assign col_last  = ((CMP_W'(tile_column) + CMP_W'(1)) >= CMP_W'(across_eff));
  assign row_last  = ((CMP_W'(tile_row) + CMP_W'(1)) >= CMP_W'(down_eff));
  assign end_hit   = tile_wrap && col_last && row_last;

  pix_rec_t rec0, rec1;

  always_comb begin
    rec0.pixel_index = idx0;
    rec0.color       = pix0;
    rec0.run_end     = (n_res == 2'd1);
    rec0.image_end   = (n_res == 2'd1) && end_hit;
    rec1.pixel_index = idx1;
    rec1.color       = pix1;
    rec1.run_end     = 1'b1;
    rec1.image_end   = end_hit;
  end

  // Next state of gathering and position
  always_comb begin
    byte_collector_next = byte_collector;
    bytes_held_next     = bytes_held;
    pixel_in_tile_next  = pixel_in_tile;
    tile_column_next    = tile_column;
    tile_row_next       = tile_row;
    if (cfg_fire) begin
      byte_collector_next = '0;
      bytes_held_next     = '0;
      pixel_in_tile_next  = '0;
      tile_column_next    = '0;
      tile_row_next       = '0;
    end else if (in_fire && fmt_ok) begin
      if (collecting) begin
        byte_collector_next = collector_add;
        bytes_held_next     = bytes_held + 2'd1;
      end else begin
        byte_collector_next = '0;
        bytes_held_next     = '0;
        pixel_in_tile_next  = p_sum[5:0];
        if (tile_wrap) begin
          if (col_last) begin
            tile_column_next = '0;
            tile_row_next    = row_last ? '0 : tile_row + TW'(1);
          end else begin
            tile_column_next = tile_column + TW'(1);
          end
        end
      end
    end
  end

  // Output queue: a transaction in always finds the queue empty after this cycle's pop
  always_comb begin
    q_slot_next[0] = q_slot[0];
    q_slot_next[1] = q_slot[1];
    if (out_fire) q_slot_next[0] = q_slot[1];
    if (in_fire && (n_res != 2'd0)) begin
      q_slot_next[0] = rec0;
      if (n_res == 2'd2) q_slot_next[1] = rec1;
    end
    q_cnt_next = q_cnt - {1'b0, out_fire} + (in_fire ? n_res : 2'd0);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      texel_format   <= FMT_RGBA8;
      tiles_across   <= 8'd1;
      tiles_down     <= 8'd1;
      byte_collector <= '0;
      bytes_held     <= '0;
      pixel_in_tile  <= '0;
      tile_column    <= '0;
      tile_row       <= '0;
      q_cnt          <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg.index)
          CFG_FORMAT: texel_format <= cfg.data[3:0];
          CFG_ACROSS: tiles_across <= cfg.data;
          CFG_DOWN:   tiles_down   <= cfg.data;
          default:    ;
        endcase
      end
      byte_collector <= byte_collector_next;
      bytes_held     <= bytes_held_next;
      pixel_in_tile  <= pixel_in_tile_next;
      tile_column    <= tile_column_next;
      tile_row       <= tile_row_next;
      q_cnt          <= q_cnt_next;
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    q_slot[0] <= q_slot_next[0];
    q_slot[1] <= q_slot_next[1];
  end

endmodule
